// ----- hw/rtl/ras_pkg.sv -----
// Package for the request arithmetic service block.
// Holds request, operation and status codes, the sequencer state type and
// the command struct for the shared iterative unit. No dependencies.
package ras_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int SERIAL_W       = 32;

    // request kinds
    localparam logic [1:0] RQ_ARITH = 2'd0;
    localparam logic [1:0] RQ_EVEN  = 2'd1;
    localparam logic [1:0] RQ_PRIME = 2'd2;
    localparam logic [1:0] RQ_NEG   = 2'd3;

    // arithmetic operations
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MUL = 3'd4;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NEG = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ARITH_WAIT,
        S_PRIME_START,
        S_PRIME_WAIT,
        S_FIN
    } t_state;

    typedef enum logic {
        UM_MUL,
        UM_DIV
    } t_unit_mode;

    typedef struct packed {
        logic       start;
        t_unit_mode mode;
    } t_unit_cmd;

endpackage

// ----- hw/rtl/ras_iter_unit.sv -----
// Shared iterative unit: shift-add multiply and restoring divide, one bit
// per cycle through a single adder/subtractor. Depends on ras_pkg.
module ras_iter_unit #(
    parameter int DATA_WIDTH = ras_pkg::DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ras_pkg::t_unit_cmd    i_cmd,
    input  logic [DATA_WIDTH-1:0] i_opa,    // multiplicand / dividend
    input  logic [DATA_WIDTH-1:0] i_opb,    // multiplier / divisor
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_acc,    // product / remainder
    output logic [DATA_WIDTH-1:0] o_shift   // quotient
);
    import ras_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    t_unit_mode            r_mode;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_acc;
    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;

    logic                  w_div;
    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH+1:0] w_p;
    logic [DATA_WIDTH+1:0] w_q;
    logic [DATA_WIDTH+1:0] w_sum;
    logic                  w_fit;
    logic                  w_start;

    assign w_start = i_cmd.start && !r_busy;
    assign w_div   = (r_mode == UM_DIV);
    assign w_trial = {r_acc, r_x[DATA_WIDTH-1]};

    // the one adder: acc + x (when y[0] is set) for multiply, trial - divisor for divide
    always_comb begin
        if (w_div) begin
            w_p = {1'b0, w_trial};
            w_q = {2'b00, r_y};
        end else begin
            w_p = {2'b00, r_acc};
            w_q = r_y[0] ? {2'b00, r_x} : '0;
        end
        w_sum = w_p + (w_div ? ~w_q : w_q) + (DATA_WIDTH+2)'(w_div);
        w_fit = !w_sum[DATA_WIDTH+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (w_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_mode <= i_cmd.mode;
            r_cnt  <= CW'(DATA_WIDTH - 1);
            r_acc  <= '0;
            r_x    <= i_opa;
            r_y    <= i_opb;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_div) begin
                r_acc <= w_fit ? w_sum[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
                r_x   <= {r_x[DATA_WIDTH-2:0], w_fit};
            end else begin
                r_acc <= w_sum[DATA_WIDTH-1:0];
                r_x   <= {r_x[DATA_WIDTH-2:0], 1'b0};
                r_y   <= {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_acc   = r_acc;
    assign o_shift = r_x;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy) else $error("unit started while busy");
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_cmd.start) |=> r_done)
        else $error("unit missed done after last step");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done longer than one cycle");

endmodule

// ----- hw/rtl/request_arith_service_core.sv -----
// Top level of the request arithmetic service block.
// Depends on ras_pkg and ras_iter_unit.
//
// Usage:
//   Slave channel (i_s_*) takes one request item: tdata holds operand_a
//   then operand_b, tuser holds req_type then arith_op. Master channel
//   (o_m_*) gives one result item per request: tdata holds answer then the
//   serial number, tuser holds status.
//   Add, subtract, even, negative, error and trivial prime cases go from
//   S_EXEC to S_FIN and raise o_m_tvalid once the output register loads.
//   Multiply and divide run on the shared shift/add unit, one bit per cycle.
//   A prime test runs a full division for each trial divisor d = 2, 3, ...
//   while d <= n/d, stopping early when a remainder is zero, so it is
//   bounded by roughly sqrt(n) trials. The next request can be accepted in
//   the cycle after the result is loaded into the output register.
//   One request is worked at a time; o_s_tready is high only when the
//   sequencer is idle. The result sits in an output register, so the next
//   request is accepted while a finished result waits for i_m_tready; a
//   stalled receiver only blocks when a second result is ready to load.
//   Reset (synchronous, active low) empties the output register, returns
//   the sequencer to idle and clears the served counter.
module request_arith_service_core #(
    parameter int DATA_WIDTH = ras_pkg::DEF_DATA_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata: operand_a, operand_b, zero pad to bytes
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // tuser: req_type [1:0], arith_op [4:2]
    input  logic [4:0] i_s_tuser,
    // result channel
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata: answer, serial, zero pad to bytes
    output logic [((DATA_WIDTH+ras_pkg::SERIAL_W+7)/8)*8-1:0] o_m_tdata,
    // tuser: status [1:0]
    output logic [1:0] o_m_tuser
);
    import ras_pkg::*;

    localparam int OUT_TDATA_W = ((DATA_WIDTH + SERIAL_W + 7) / 8) * 8;

    // latched request
    t_state                r_state, n_state;
    logic [1:0]            r_kind;
    logic [2:0]            r_op;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    // trial divisor for the prime test
    logic [DATA_WIDTH-1:0] r_d, n_d;
    // result being built
    logic [DATA_WIDTH-1:0] r_ans, n_ans;
    logic [1:0]            r_st, n_st;
    // output register and served counter
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_ans;
    logic [1:0]            r_out_st;
    logic [SERIAL_W-1:0]   r_out_serial;
    logic [SERIAL_W-1:0]   r_count;

    t_unit_cmd             w_cmd;
    logic [DATA_WIDTH-1:0] w_opa, w_opb;
    logic                  w_busy, w_done;
    logic [DATA_WIDTH-1:0] w_acc, w_shift;
    logic                  w_accept;
    logic                  w_load;
    logic                  w_exec_unit;
    logic                  w_exec_prime;
    logic                  w_sign_a, w_sign_b;
    logic [DATA_WIDTH-1:0] w_mag_a, w_mag_b;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_load   = (r_state == S_FIN) && (!r_out_valid || i_m_tready);
    assign w_sign_a = r_a[DATA_WIDTH-1];
    assign w_sign_b = r_b[DATA_WIDTH-1];
    assign w_mag_a  = w_sign_a ? (DATA_WIDTH'(0) - r_a) : r_a;
    assign w_mag_b  = w_sign_b ? (DATA_WIDTH'(0) - r_b) : r_b;

    // requests that need the shared unit
    assign w_exec_unit  = (r_kind == RQ_ARITH) &&
                          (((r_op == OP_DIV) && (r_b != '0)) || (r_op == OP_MUL));
    assign w_exec_prime = (r_kind == RQ_PRIME) && !w_sign_a &&
                          (r_a > DATA_WIDTH'(2));

    // unit operands: raw bits for multiply (low half wraps right for signed),
    // magnitudes for divide, n and d for the prime test
    always_comb begin
        if (r_kind == RQ_PRIME) begin
            w_opa = r_a;
            w_opb = r_d;
        end else if (r_op == OP_MUL) begin
            w_opa = r_a;
            w_opb = r_b;
        end else begin
            w_opa = w_mag_a;
            w_opb = w_mag_b;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec_unit)       n_state = S_ARITH_WAIT;
                else if (w_exec_prime) n_state = S_PRIME_START;
                else                   n_state = S_FIN;
            end
            S_ARITH_WAIT: begin
                if (w_done) n_state = S_FIN;
            end
            S_PRIME_START: begin
                n_state = S_PRIME_WAIT;
            end
            S_PRIME_WAIT: begin
                if (w_done) begin
                    if ((r_d > w_shift) || (w_acc == '0)) n_state = S_FIN;
                    else                                  n_state = S_PRIME_START;
                end
            end
            S_FIN: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs and datapath next values
    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.mode  = UM_DIV;
        n_ans       = r_ans;
        n_st        = r_st;
        n_d         = r_d;
        o_s_tready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
            end
            S_EXEC: begin
                n_ans = '0;
                n_st  = ST_OK;
                case (r_kind)
                    RQ_ARITH: begin
                        case (r_op)
                            OP_ADD: n_ans = r_a + r_b;
                            OP_SUB: n_ans = r_a - r_b;
                            OP_DIV: begin
                                if (r_b == '0) n_st = ST_ERR;
                                else           w_cmd.start = 1'b1;
                            end
                            OP_MUL: begin
                                w_cmd.start = 1'b1;
                                w_cmd.mode  = UM_MUL;
                            end
                            default: n_st = ST_ERR;
                        endcase
                    end
                    RQ_EVEN: n_ans = DATA_WIDTH'(!r_a[0]);
                    RQ_PRIME: begin
                        if (w_exec_prime) n_d   = DATA_WIDTH'(2);
                        else              n_ans = DATA_WIDTH'(1);
                    end
                    RQ_NEG: begin
                        n_ans = DATA_WIDTH'(w_sign_a);
                        n_st  = w_sign_a ? ST_NEG : ST_OK;
                    end
                    default: n_st = ST_ERR;
                endcase
            end
            S_ARITH_WAIT: begin
                if (w_done) begin
                    if (r_op == OP_MUL)          n_ans = w_acc;
                    else if (w_sign_a ^ w_sign_b) n_ans = DATA_WIDTH'(0) - w_shift;
                    else                          n_ans = w_shift;
                end
            end
            S_PRIME_START: begin
                w_cmd.start = 1'b1;
            end
            S_PRIME_WAIT: begin
                // d > n/d: no divisor up to sqrt(n), so n is prime
                if (w_done) begin
                    if (r_d > w_shift)     n_ans = DATA_WIDTH'(1);
                    else if (w_acc == '0)  n_ans = '0;
                    else                   n_d   = r_d + 1'b1;
                end
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    ras_iter_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_acc   (w_acc),
        .o_shift (w_shift)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_count     <= r_count + 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_s_tuser[1:0];
            r_op   <= i_s_tuser[4:2];
            r_a    <= i_s_tdata[DATA_WIDTH-1:0];
            r_b    <= i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
        end
        r_ans <= n_ans;
        r_st  <= n_st;
        r_d   <= n_d;
        if (w_load) begin
            r_out_ans    <= r_ans;
            r_out_st     <= r_st;
            r_out_serial <= r_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_serial, r_out_ans});
    assign o_m_tuser  = r_out_st;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_count == $past(r_count) + 1'b1))
        else $error("served count did not advance on result load");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_ARITH_WAIT || r_state == S_PRIME_WAIT))
        else $error("unit finished outside a wait state");
    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_busy) else $error("ready while unit busy");

endmodule
